FILE: hw/rtl/psl_pkg.sv
// Shared types and constants for the prime sieve lister.
`default_nettype none
package psl_pkg;

   localparam int ORDINAL_W = 17;
   localparam int PRIME_W   = 16;
   localparam int GAP_W     = 16;
   localparam int LIMIT_W   = 17;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

   typedef struct packed {
      logic [ORDINAL_W-1:0] ordinal;
      logic [PRIME_W-1:0]   prime;
      logic [GAP_W-1:0]     gap;
      logic                 exhausted;
   } result_type;

endpackage
`default_nettype wire

FILE: hw/rtl/psl_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none
module psl_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wr_data;
         end else begin
            rd_data <= mem[addr];
         end
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/psl_ctrl.sv
// Sequencer: clear pass, sieve strikes and forward scan over the composite map.
`default_nettype none
module psl_ctrl #(
   parameter int MAX_LIMIT = 65536,
   localparam int AW = $clog2(MAX_LIMIT),
   localparam int CW = $clog2(MAX_LIMIT + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          restart,
   input  wire logic          stale,
   input  wire logic [CW-1:0] lim,
   output logic               busy,
   output logic               res_vld,
   output psl_pkg::result_type res,
   output logic               mem_en,
   output logic               mem_we,
   output logic [AW-1:0]      mem_addr,
   output logic               mem_wr_data,
   input  wire logic          mem_rd_data
);

   localparam int KW = CW + 1;
   localparam int XW = (CW > psl_pkg::ORDINAL_W) ? CW : psl_pkg::ORDINAL_W;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CLEAR    = 3'd1;
   localparam logic [2:0] ST_BASE_RD  = 3'd2;
   localparam logic [2:0] ST_BASE_CHK = 3'd3;
   localparam logic [2:0] ST_STRIKE   = 3'd4;
   localparam logic [2:0] ST_SCAN     = 3'd5;

   localparam logic [CW-1:0] FIRST_PRIME = CW'(2);

   logic [2:0]                      state_ff, state_in;
   logic                            sieved_ff, sieved_in;
   logic [CW-1:0]                   cursor_ff, cursor_in;
   logic [psl_pkg::ORDINAL_W-1:0]   count_ff, count_in;
   logic [CW-1:0]                   prev_ff, prev_in;
   logic                            pend_vld_ff, pend_vld_in;
   logic [CW-1:0]                   pend_addr_ff, pend_addr_in;
   logic [KW-1:0]                   k_ff, k_in;
   logic [KW-1:0]                   base_ff, base_in;
   logic [KW-1:0]                   sq_ff, sq_in;

   logic [KW-1:0] lim_k;
   logic [KW-1:0] base_next;
   logic [KW-1:0] sq_next;
   logic [CW-1:0] gap_c;
   logic [XW-1:0] pend_x;
   logic [XW-1:0] gap_x;

   assign lim_k     = KW'(lim);
   assign base_next = base_ff + KW'(1);
   // (b+1)^2 = b^2 + 2b + 1
   assign sq_next   = sq_ff + {base_ff[KW-2:0], 1'b0} + KW'(1);
   assign gap_c     = pend_addr_ff - prev_ff;
   assign pend_x    = XW'(pend_addr_ff);
   assign gap_x     = XW'(gap_c);
   assign busy      = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      sieved_in    = sieved_ff;
      cursor_in    = cursor_ff;
      count_in     = count_ff;
      prev_in      = prev_ff;
      pend_vld_in  = 1'b0;
      pend_addr_in = pend_addr_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      sq_in        = sq_ff;
      mem_en       = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = cursor_ff[AW-1:0];
      mem_wr_data  = 1'b0;
      res_vld      = 1'b0;
      res          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (restart || !sieved_ff) begin
                  state_in = ST_CLEAR;
                  k_in     = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_CLEAR: begin
            // only entries below the limit are ever read
            if (k_ff < lim_k) begin
               mem_en   = 1'b1;
               mem_we   = 1'b1;
               mem_addr = k_ff[AW-1:0];
               k_in     = k_ff + KW'(1);
            end else begin
               state_in = ST_BASE_RD;
               base_in  = KW'(2);
               sq_in    = KW'(4);
            end
         end
         ST_BASE_RD: begin
            if (sq_ff >= lim_k) begin
               state_in  = ST_SCAN;
               sieved_in = 1'b1;
               cursor_in = FIRST_PRIME;
               count_in  = '0;
               prev_in   = FIRST_PRIME;
            end else begin
               mem_en   = 1'b1;
               mem_addr = base_ff[AW-1:0];
               state_in = ST_BASE_CHK;
            end
         end
         ST_BASE_CHK: begin
            if (mem_rd_data) begin
               base_in  = base_next;
               sq_in    = sq_next;
               state_in = ST_BASE_RD;
            end else begin
               k_in     = sq_ff;
               state_in = ST_STRIKE;
            end
         end
         ST_STRIKE: begin
            if (k_ff < lim_k) begin
               mem_en      = 1'b1;
               mem_we      = 1'b1;
               mem_addr    = k_ff[AW-1:0];
               mem_wr_data = 1'b1;
               k_in        = k_ff + base_ff;
            end else begin
               base_in  = base_next;
               sq_in    = sq_next;
               state_in = ST_BASE_RD;
            end
         end
         ST_SCAN: begin
            // one read issued per cycle; data for pend_addr arrives in the next cycle
            if (pend_vld_ff && !mem_rd_data) begin
               res_vld       = 1'b1;
               res.ordinal   = count_ff + psl_pkg::ORDINAL_W'(1);
               res.prime     = pend_x[psl_pkg::PRIME_W-1:0];
               res.gap       = gap_x[psl_pkg::GAP_W-1:0];
               res.exhausted = 1'b0;
               count_in      = count_ff + psl_pkg::ORDINAL_W'(1);
               prev_in       = pend_addr_ff;
               cursor_in     = pend_addr_ff + CW'(1);
               state_in      = ST_IDLE;
            end else if (cursor_ff < lim) begin
               mem_en       = 1'b1;
               mem_addr     = cursor_ff[AW-1:0];
               pend_vld_in  = 1'b1;
               pend_addr_in = cursor_ff;
               cursor_in    = cursor_ff + CW'(1);
            end else begin
               res_vld       = 1'b1;
               res.exhausted = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (stale) begin
         sieved_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         sieved_ff   <= 1'b0;
         cursor_ff   <= FIRST_PRIME;
         count_ff    <= '0;
         prev_ff     <= FIRST_PRIME;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sieved_ff   <= sieved_in;
         cursor_ff   <= cursor_in;
         count_ff    <= count_in;
         prev_ff     <= prev_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      k_ff         <= k_in;
      base_ff      <= base_in;
      sq_ff        <= sq_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/prime_sieve_lister_unit.sv
// Prime sieve lister: one prime below the configured limit per request.
//
// Request: pulse start with req_restart while busy is low. restart=1 (or the
// first request after reset or after a limit write) clears the composite map
// below the limit and runs a full Sieve of Eratosthenes before answering;
// restart=0 continues from the last prime returned.
// Response: rsp_valid is high for one cycle with rsp_ordinal, rsp_prime,
// rsp_gap and rsp_exhausted. It cannot be held off. Once primes run out,
// every plain (restart=0) request answers exhausted with zero fields.
// Sequence: a plain request scans the map from the last prime returned, one
// map entry read a cycle on a single-port RAM with registered read data, and
// rsp_valid rises once the next prime is found; busy falls in the same cycle.
// A sieving request first clears the map below the limit, then reads and
// checks each base below sqrt(lim), strikes the multiples of each prime base
// from its square, and then starts the scan, which begins at the prime 2. One
// request is in flight at a time.
// Configuration: csr_wr_en/csr_wr_data writes the limit (values above
// MAX_LIMIT saturate); write only while busy is low. Reset sets the limit
// to 65536 and marks the map unsieved; no clearing runs at reset.
`default_nettype none
module prime_sieve_lister_unit #(
   parameter int MAX_LIMIT = 65536
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_restart,
   output logic                                 rsp_valid,
   output logic [psl_pkg::ORDINAL_W-1:0]        rsp_ordinal,
   output logic [psl_pkg::PRIME_W-1:0]          rsp_prime,
   output logic [psl_pkg::GAP_W-1:0]            rsp_gap,
   output logic                                 rsp_exhausted,
   input  wire logic                            csr_wr_en,
   input  wire logic [psl_pkg::LIMIT_W-1:0]     csr_wr_data
);

   localparam int AW = $clog2(MAX_LIMIT);
   localparam int CW = $clog2(MAX_LIMIT + 1);
   localparam int XW = (CW > psl_pkg::LIMIT_W) ? CW : psl_pkg::LIMIT_W;

   logic [psl_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic                        rsp_valid_ff;
   psl_pkg::result_type         rsp_ff;

   logic [XW-1:0]       lim_x;
   logic [XW-1:0]       max_x;
   logic [XW-1:0]       lim_sat;
   logic [CW-1:0]       lim;
   logic                res_vld;
   psl_pkg::result_type res;
   logic                mem_en;
   logic                mem_we;
   logic [AW-1:0]       mem_addr;
   logic                mem_wr_data;
   logic                mem_rd_data;

   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;
   assign lim_x    = XW'(limit_ff);
   assign max_x    = XW'(MAX_LIMIT);
   assign lim_sat  = (lim_x > max_x) ? max_x : lim_x;
   assign lim      = lim_sat[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= psl_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= res_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (res_vld) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ordinal   = rsp_ff.ordinal;
   assign rsp_prime     = rsp_ff.prime;
   assign rsp_gap       = rsp_ff.gap;
   assign rsp_exhausted = rsp_ff.exhausted;

   psl_ctrl #(
      .MAX_LIMIT (MAX_LIMIT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .restart     (req_restart),
      .stale       (csr_wr_en),
      .lim         (lim),
      .busy        (busy),
      .res_vld     (res_vld),
      .res         (res),
      .mem_en      (mem_en),
      .mem_we      (mem_we),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   psl_ram #(
      .WIDTH (1),
      .DEPTH (MAX_LIMIT)
   ) u_map (
      .clock   (clock),
      .en      (mem_en),
      .we      (mem_we),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule
`default_nettype wire
